// File: hdl/vcri_pkg.sv
package vcri_pkg;

   localparam int NAMETABLE_BYTES_DEF  = 2048;
   localparam int SPRITE_RAM_BYTES_DEF = 256;
   localparam int PALETTE_BYTES_DEF    = 32;

   typedef enum logic [1:0] {
      OP_READ   = 2'd0,
      OP_WRITE  = 2'd1,
      OP_VBLANK = 2'd2,
      OP_SPRITE = 2'd3
   } op_type;

   localparam logic [15:0] ADDR_CTRL    = 16'h2000;
   localparam logic [15:0] ADDR_MASK    = 16'h2001;
   localparam logic [15:0] ADDR_STATUS  = 16'h2002;
   localparam logic [15:0] ADDR_OAMADDR = 16'h2003;
   localparam logic [15:0] ADDR_OAMDATA = 16'h2004;
   localparam logic [15:0] ADDR_SCROLL  = 16'h2005;
   localparam logic [15:0] ADDR_VADDR   = 16'h2006;
   localparam logic [15:0] ADDR_VDATA   = 16'h2007;
   localparam logic [15:0] ADDR_PAD     = 16'h4016;
   localparam logic [15:0] ADDR_BANKSEL = 16'h8000;
   localparam logic [15:0] ADDR_BANKDAT = 16'h8001;
   localparam logic [15:0] ADDR_MIRROR  = 16'hA000;
   localparam logic [13:0] PALETTE_BASE = 14'h3F00;

   typedef struct packed {
      logic [1:0]  operation;
      logic [15:0] address;
      logic [7:0]  data;
      logic [7:0]  buttons;
   } req_type;

   typedef struct packed {
      logic [7:0]  read_data;
      logic [7:0]  ctrl_reg;
      logic [7:0]  mask_reg;
      logic [7:0]  scroll_x;
      logic [7:0]  scroll_y;
      logic        mirror_mode;
      logic [31:0] chr_windows_low;
      logic [31:0] chr_windows_high;
   } rsp_type;

endpackage

// File: hdl/vcri_chr_map.sv
module vcri_chr_map (
   input  logic [63:0] bank_flat,
   input  logic        swap,
   output logic [31:0] win_low,
   output logic [31:0] win_high
);
   logic [31:0] two_k;
   logic [31:0] one_k;

   always_comb begin
      two_k = {bank_flat[15:9], 1'b1, bank_flat[15:9], 1'b0,
               bank_flat[7:1], 1'b1, bank_flat[7:1], 1'b0};
      one_k = bank_flat[47:16];
      win_low  = swap ? one_k : two_k;
      win_high = swap ? two_k : one_k;
   end
endmodule

// File: hdl/video_chip_register_interface.sv
// Channel | Direction | Payload
// req     | in        | vcri_pkg::req_type (operation, address, data, buttons)
// rsp     | out       | vcri_pkg::rsp_type (read data and renderer registers)
// An item is accepted in idle, then passes through execute, where the RAM word
// read at the accepting edge is used and written back. Its result is offered from
// the next cycle, and no new item is accepted until that result has been taken.
// After reset a clearing pass zeroes the RAMs, during which no item is accepted.
// A stalled result holds in the output register; the next item waits for it.
module video_chip_register_interface #(
   parameter int NAMETABLE_BYTES  = vcri_pkg::NAMETABLE_BYTES_DEF,
   parameter int SPRITE_RAM_BYTES = vcri_pkg::SPRITE_RAM_BYTES_DEF,
   parameter int PALETTE_BYTES    = vcri_pkg::PALETTE_BYTES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  vcri_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output vcri_pkg::rsp_type rsp_data
);
   localparam int NTW = $clog2(NAMETABLE_BYTES);
   localparam int SPW = $clog2(SPRITE_RAM_BYTES);
   localparam int PLW = $clog2(PALETTE_BYTES);

   typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_EXEC, ST_OUT} state_type;

   logic [7:0] nt_mem [NAMETABLE_BYTES];
   logic [7:0] sp_mem [SPRITE_RAM_BYTES];
   logic [7:0] pl_mem [PALETTE_BYTES];

   state_type         state_ff;
   logic [NTW:0]      clr_ff;
   vcri_pkg::req_type req_ff;
   logic [7:0]  nt_q_ff, sp_q_ff, pl_q_ff;
   logic [7:0]  sp_ptr_ff, rbuf_ff, obus_ff, ctrl_ff, mask_ff, sx_ff, sy_ff;
   logic [7:0]  bsel_ff, pad_ff;
   logic [15:0] vaddr_ff;
   logic        toggle_ff, mirror_ff, strobe_ff;
   logic [2:0]  flags_ff;
   logic [7:0]  bank_ff [8];
   logic [7:0]  rd_ff;

   logic [13:0]    va;
   logic           is_pal;
   logic [1:0]     ntn;
   logic [NTW-1:0] nt_addr;
   logic [PLW-1:0] pl_addr;
   logic [15:0]    vnext;
   logic [63:0]    bank_flat;
   logic [31:0]    win_low, win_high;

   always_comb begin
      va      = vaddr_ff[13:0];
      is_pal  = va >= vcri_pkg::PALETTE_BASE;
      ntn     = va[11:10];
      nt_addr = NTW'({(mirror_ff ? ntn[0] : ntn[1]), va[9:0]});
      pl_addr = (va[1:0] == 2'b00) ? PLW'({1'b0, va[3:0]}) : PLW'(va[4:0]);
      vnext   = vaddr_ff + (ctrl_ff[2] ? 16'd32 : 16'd1);
      for (int i = 0; i < 8; i++) bank_flat[i*8 +: 8] = bank_ff[i];
   end

   vcri_chr_map u_chr (
      .bank_flat(bank_flat), .swap(bsel_ff[7]),
      .win_low(win_low), .win_high(win_high)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_OUT);

   // Memories: registered reads, with write-back in the execute state.
   always_ff @(posedge clock) begin
      nt_q_ff <= nt_mem[nt_addr];
      sp_q_ff <= sp_mem[SPW'(sp_ptr_ff)];
      pl_q_ff <= pl_mem[pl_addr];
      if (state_ff == ST_CLEAR) begin
         nt_mem[clr_ff[NTW-1:0]] <= 8'h00;
         sp_mem[clr_ff[SPW-1:0]] <= 8'h00;
         pl_mem[clr_ff[PLW-1:0]] <= 8'h00;
      end else if (state_ff == ST_EXEC && req_ff.operation == vcri_pkg::OP_WRITE) begin
         if (req_ff.address == vcri_pkg::ADDR_OAMDATA)
            sp_mem[SPW'(sp_ptr_ff)] <= req_ff.data;
         if (req_ff.address == vcri_pkg::ADDR_VDATA) begin
            if (!is_pal) begin
               nt_mem[nt_addr] <= req_ff.data;
            end else begin
               pl_mem[pl_addr] <= req_ff.data;
               if (va[1:0] == 2'b00)
                  pl_mem[PLW'({1'b1, va[3:0]})] <= req_ff.data;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff <= '0;
         sp_ptr_ff <= '0; rbuf_ff <= '0; obus_ff <= '0; ctrl_ff <= '0;
         mask_ff <= '0; sx_ff <= '0; sy_ff <= '0; bsel_ff <= '0; pad_ff <= '0;
         vaddr_ff <= '0; toggle_ff <= 1'b0; mirror_ff <= 1'b0;
         strobe_ff <= 1'b0; flags_ff <= '0;
         for (int i = 0; i < 8; i++) bank_ff[i] <= 8'(i);
      end else begin
         unique case (state_ff)
            ST_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == (NTW+1)'(NAMETABLE_BYTES - 1)) state_ff <= ST_IDLE;
            end
            ST_IDLE: begin
               if (req_valid) begin
                  req_ff <= req_data;
                  state_ff <= ST_EXEC;
               end
            end
            ST_EXEC: begin
               logic [7:0] rd;
               logic [7:0] d;
               logic [15:0] a;
               rd = '0;
               d  = req_ff.data;
               a  = req_ff.address;
               unique case (vcri_pkg::op_type'(req_ff.operation))
                  vcri_pkg::OP_READ: begin
                     priority if (a == vcri_pkg::ADDR_STATUS) begin
                        rd = {flags_ff, obus_ff[4:0]};
                        flags_ff[2] <= 1'b0;
                        toggle_ff <= 1'b0;
                     end else if (a == vcri_pkg::ADDR_OAMDATA) begin
                        rd = sp_q_ff;
                        obus_ff <= sp_q_ff;
                     end else if (a == vcri_pkg::ADDR_VDATA) begin
                        if (is_pal) rd = pl_q_ff;
                        else begin
                           rd = rbuf_ff;
                           rbuf_ff <= nt_q_ff;
                        end
                        vaddr_ff <= vnext;
                        obus_ff <= rd;
                     end else if (a == vcri_pkg::ADDR_PAD) begin
                        if (strobe_ff) rd = {7'd0, req_ff.buttons[0]};
                        else begin
                           rd = {7'd0, pad_ff[0]};
                           pad_ff <= {1'b0, pad_ff[7:1]};
                        end
                     end else begin
                        rd = '0;
                     end
                  end
                  vcri_pkg::OP_WRITE: begin
                     if (a[15:3] == vcri_pkg::ADDR_CTRL[15:3]) obus_ff <= d;
                     priority if (a == vcri_pkg::ADDR_CTRL) ctrl_ff <= d;
                     else if (a == vcri_pkg::ADDR_MASK) mask_ff <= d;
                     else if (a == vcri_pkg::ADDR_OAMADDR) sp_ptr_ff <= d;
                     else if (a == vcri_pkg::ADDR_OAMDATA) sp_ptr_ff <= sp_ptr_ff + 8'd1;
                     else if (a == vcri_pkg::ADDR_SCROLL) begin
                        if (!toggle_ff) sx_ff <= d; else sy_ff <= d;
                        toggle_ff <= !toggle_ff;
                     end else if (a == vcri_pkg::ADDR_VADDR) begin
                        if (!toggle_ff) vaddr_ff[15:8] <= d; else vaddr_ff[7:0] <= d;
                        toggle_ff <= !toggle_ff;
                     end else if (a == vcri_pkg::ADDR_VDATA) vaddr_ff <= vnext;
                     else if (a == vcri_pkg::ADDR_BANKSEL) bsel_ff <= d;
                     else if (a == vcri_pkg::ADDR_BANKDAT) bank_ff[bsel_ff[2:0]] <= d;
                     else if (a == vcri_pkg::ADDR_MIRROR) mirror_ff <= !d[0];
                     else if (a == vcri_pkg::ADDR_PAD) begin
                        strobe_ff <= d[0];
                        if (d[0]) pad_ff <= req_ff.buttons;
                     end
                  end
                  vcri_pkg::OP_VBLANK: flags_ff[2] <= d[0];
                  vcri_pkg::OP_SPRITE: flags_ff[1] <= d[0];
                  default: ;
               endcase
               rd_ff <= rd;
               state_ff <= ST_OUT;
            end
            ST_OUT: begin
               if (!rsp_stall) state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // Renderer-facing fields follow the registers, which settle before ST_OUT.
   always_comb begin
      rsp_data.read_data        = rd_ff;
      rsp_data.ctrl_reg         = ctrl_ff;
      rsp_data.mask_reg         = mask_ff;
      rsp_data.scroll_x         = sx_ff;
      rsp_data.scroll_y         = sy_ff;
      rsp_data.mirror_mode      = mirror_ff;
      rsp_data.chr_windows_low  = win_low;
      rsp_data.chr_windows_high = win_high;
   end
endmodule

// File: hdl/vcri_checker.sv
module vcri_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input vcri_pkg::rsp_type rsp_data
);
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall) else $error("item accepted while result pending");
   a_rsp_after_req: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> ##1 rsp_valid) else $error("result missing");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled result changed");
   a_clear_after_reset: assert property (@(posedge clock) disable iff (reset)
      $fell(reset) |-> req_stall) else $error("item accepted before RAM clearing");
endmodule

bind video_chip_register_interface vcri_checker u_vcri_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
);

// File: tb/tb.sv
module tb;

   localparam int ITEM_COUNT   = 1050;
   localparam int QUIET_LIMIT  = 20000;
   localparam int CALM_TAIL    = 150;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   vcri_pkg::req_type req_data = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   vcri_pkg::rsp_type rsp_data;

   video_chip_register_interface DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   always #1 clock = ~clock;

   // Predicted chip state.
   logic [7:0]  nt_mem [0:2047];
   logic [7:0]  pal_mem [0:31];
   logic [7:0]  oam_mem [0:255];
   logic [7:0]  oam_ptr;
   logic [15:0] vaddr;
   logic        toggle;
   logic [7:0]  rd_buffer;
   logic [2:0]  status;
   logic [7:0]  open_bus;
   logic [7:0]  ctrl_q, mask_q, sx_q, sy_q, bank_sel;
   logic [7:0]  banks [0:7];
   logic        vertical;
   logic [7:0]  pad_sr;
   logic        pad_strobe;

   vcri_pkg::rsp_type response_queue[$];
   int      mismatches = 0;
   int      responses_seen = 0;
   int      reads_seen = 0;
   int      quiet_cycles = 0;
   int      stall_left = 0;
   bit      calm = 1'b0;
   bit      stim_done = 1'b0;

   function automatic int nt_slot(logic [15:0] a);
      logic [11:0] t;
      logic [1:0]  n;
      logic        page;
      t = a[11:0];
      n = t[11:10];
      page = vertical ? n[0] : n[1];
      return int'({page, t[9:0]});
   endfunction

   function automatic void advance_vaddr();
      vaddr = vaddr + (ctrl_q[2] ? 16'd32 : 16'd1);
   endfunction

   function automatic vcri_pkg::rsp_type predict_bus(vcri_pkg::req_type r);
      vcri_pkg::rsp_type e;
      logic [13:0] a;
      logic [4:0]  p;
      logic [7:0]  w [0:7];
      e = '0;
      a = vaddr[13:0];
      if (r.operation == vcri_pkg::OP_READ) begin
         case (r.address)
            vcri_pkg::ADDR_STATUS: begin
               e.read_data = {status, open_bus[4:0]};
               status[2] = 1'b0;
               toggle = 1'b0;
            end
            vcri_pkg::ADDR_OAMDATA: begin
               e.read_data = oam_mem[oam_ptr];
               open_bus = e.read_data;
            end
            vcri_pkg::ADDR_VDATA: begin
               if (a >= vcri_pkg::PALETTE_BASE) begin
                  p = a[4:0];
                  if (p[1:0] == 2'b00) p[4] = 1'b0;
                  e.read_data = pal_mem[p];
               end else begin
                  e.read_data = rd_buffer;
                  rd_buffer = nt_mem[nt_slot(vaddr)];
               end
               advance_vaddr();
               open_bus = e.read_data;
            end
            vcri_pkg::ADDR_PAD: begin
               if (pad_strobe) e.read_data = {7'd0, r.buttons[0]};
               else begin
                  e.read_data = {7'd0, pad_sr[0]};
                  pad_sr = pad_sr >> 1;
               end
            end
            default: ;
         endcase
      end else if (r.operation == vcri_pkg::OP_WRITE) begin
         if (r.address >= vcri_pkg::ADDR_CTRL && r.address <= vcri_pkg::ADDR_VDATA)
            open_bus = r.data;
         case (r.address)
            vcri_pkg::ADDR_CTRL:    ctrl_q = r.data;
            vcri_pkg::ADDR_MASK:    mask_q = r.data;
            vcri_pkg::ADDR_OAMADDR: oam_ptr = r.data;
            vcri_pkg::ADDR_OAMDATA: begin
               oam_mem[oam_ptr] = r.data;
               oam_ptr++;
            end
            vcri_pkg::ADDR_SCROLL: begin
               if (!toggle) sx_q = r.data; else sy_q = r.data;
               toggle = ~toggle;
            end
            vcri_pkg::ADDR_VADDR: begin
               if (!toggle) vaddr[15:8] = r.data; else vaddr[7:0] = r.data;
               toggle = ~toggle;
            end
            vcri_pkg::ADDR_VDATA: begin
               if (a >= vcri_pkg::PALETTE_BASE) begin
                  p = a[4:0];
                  if (p[1:0] == 2'b00) begin
                     pal_mem[{1'b0, p[3:0]}] = r.data;
                     pal_mem[{1'b1, p[3:0]}] = r.data;
                  end else pal_mem[p] = r.data;
               end else nt_mem[nt_slot(vaddr)] = r.data;
               advance_vaddr();
            end
            vcri_pkg::ADDR_BANKSEL: bank_sel = r.data;
            vcri_pkg::ADDR_BANKDAT: banks[bank_sel[2:0]] = r.data;
            vcri_pkg::ADDR_MIRROR:  vertical = ~r.data[0];
            vcri_pkg::ADDR_PAD: begin
               pad_strobe = r.data[0];
               if (pad_strobe) pad_sr = r.buttons;
            end
            default: ;
         endcase
      end else if (r.operation == vcri_pkg::OP_VBLANK) status[2] = r.data[0];
      else status[1] = r.data[0];

      for (int i = 0; i < 4; i++) begin
         logic [7:0] pair, single;
         pair = {banks[i / 2][7:1], i[0]};
         single = banks[2 + i];
         w[i]     = bank_sel[7] ? single : pair;
         w[4 + i] = bank_sel[7] ? pair : single;
      end
      e.ctrl_reg = ctrl_q;
      e.mask_reg = mask_q;
      e.scroll_x = sx_q;
      e.scroll_y = sy_q;
      e.mirror_mode = vertical;
      e.chr_windows_low  = {w[3], w[2], w[1], w[0]};
      e.chr_windows_high = {w[7], w[6], w[5], w[4]};
      return e;
   endfunction

   function automatic void clear_chip();
      foreach (nt_mem[i]) nt_mem[i] = '0;
      foreach (pal_mem[i]) pal_mem[i] = '0;
      foreach (oam_mem[i]) oam_mem[i] = '0;
      foreach (banks[i]) banks[i] = i[7:0];
      oam_ptr = '0; vaddr = '0; toggle = 1'b0; rd_buffer = '0; status = '0;
      open_bus = '0; ctrl_q = '0; mask_q = '0; sx_q = '0; sy_q = '0;
      bank_sel = '0; vertical = 1'b0; pad_sr = '0; pad_strobe = 1'b0;
   endfunction

   // Sends one item, idling first at random, and records its expected result.
   task automatic send_item(vcri_pkg::req_type r, bit fixed_check, logic [7:0] fixed_read);
      vcri_pkg::rsp_type e;
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
      end
      req_data  <= r;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      e = predict_bus(r);
      if (fixed_check && e.read_data !== fixed_read) begin
         mismatches++;
         if (mismatches <= 10)
            $display("table row read %h expected %h from prediction", fixed_read, e.read_data);
      end
      if (fixed_check) e.read_data = fixed_read;
      response_queue.push_back(e);
      @(negedge clock);
   endtask

   function automatic vcri_pkg::req_type make_item(vcri_pkg::op_type op, logic [15:0] a,
                                                   logic [7:0] d, logic [7:0] b);
      vcri_pkg::req_type r;
      r.operation = op; r.address = a; r.data = d; r.buttons = b;
      return r;
   endfunction

   // Mostly well-formed register traffic with random content, some noise.
   function automatic vcri_pkg::req_type random_item();
      logic [15:0] regs [0:11];
      int pick;
      regs = '{vcri_pkg::ADDR_CTRL, vcri_pkg::ADDR_MASK, vcri_pkg::ADDR_STATUS,
               vcri_pkg::ADDR_OAMADDR, vcri_pkg::ADDR_OAMDATA, vcri_pkg::ADDR_SCROLL,
               vcri_pkg::ADDR_VADDR, vcri_pkg::ADDR_VDATA, vcri_pkg::ADDR_PAD,
               vcri_pkg::ADDR_BANKSEL, vcri_pkg::ADDR_BANKDAT, vcri_pkg::ADDR_MIRROR};
      pick = $urandom_range(0, 99);
      if (pick < 10)
         return make_item(vcri_pkg::op_type'($urandom_range(2, 3)), 16'($urandom),
                          8'($urandom), 8'($urandom));
      if (pick < 18)
         return make_item(vcri_pkg::op_type'($urandom_range(0, 1)), 16'($urandom),
                          8'($urandom), 8'($urandom));
      if (pick < 28)
         // Point the video address at palette or nametable space.
         return make_item(vcri_pkg::OP_WRITE, vcri_pkg::ADDR_VADDR,
                          $urandom_range(0, 1) ? 8'h3F : 8'($urandom_range(0, 8'h3F)),
                          8'($urandom));
      return make_item(vcri_pkg::op_type'($urandom_range(0, 1)), regs[$urandom_range(0, 11)],
                       8'($urandom), 8'($urandom));
   endfunction

   // Directed table: expected read data typed in only where obvious.
   typedef struct {
      vcri_pkg::req_type r;
      bit                fixed;
      logic [7:0]        rd;
   } row_type;

   initial begin
      row_type rows [$];
      clear_chip();
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      rows = '{
         '{make_item(vcri_pkg::OP_READ,   vcri_pkg::ADDR_STATUS,  8'h00, 8'h00), 1, 8'h00},
         '{make_item(vcri_pkg::OP_READ,   16'hFFFF,               8'hFF, 8'hFF), 1, 8'h00},
         '{make_item(vcri_pkg::OP_WRITE,  vcri_pkg::ADDR_CTRL,    8'hFF, 8'h00), 0, 8'h00},
         '{make_item(vcri_pkg::OP_WRITE,  vcri_pkg::ADDR_CTRL,    8'h00, 8'h00), 0, 8'h00},
         '{make_item(vcri_pkg::OP_WRITE,  vcri_pkg::ADDR_MASK,    8'hA5, 8'h00), 0, 8'h00},
         '{make_item(vcri_pkg::OP_VBLANK, 16'h0000,               8'h01, 8'h00), 0, 8'h00},
         '{make_item(vcri_pkg::OP_SPRITE, 16'h0000,               8'hFF, 8'h00), 0, 8'h00},
         '{make_item(vcri_pkg::OP_READ,   vcri_pkg::ADDR_STATUS,  8'h00, 8'h00), 1, 8'hC5},
         '{make_item(vcri_pkg::OP_SPRITE, 16'h0000,               8'hFE, 8'h00), 0, 8'h00},
         '{make_item(vcri_pkg::OP_WRITE,  vcri_pkg::ADDR_SCROLL,  8'hFF, 8'h00), 0, 8'h00},
         '{make_item(vcri_pkg::OP_WRITE,  vcri_pkg::ADDR_SCROLL,  8'h80, 8'h00), 0, 8'h00},
         '{make_item(vcri_pkg::OP_WRITE,  vcri_pkg::ADDR_OAMADDR, 8'hFF, 8'h00), 0, 8'h00},
         '{make_item(vcri_pkg::OP_WRITE,  vcri_pkg::ADDR_OAMDATA, 8'h5A, 8'h00), 0, 8'h00},
         '{make_item(vcri_pkg::OP_READ,   vcri_pkg::ADDR_OAMDATA, 8'h00, 8'h00), 0, 8'h00},
         '{make_item(vcri_pkg::OP_WRITE,  vcri_pkg::ADDR_VADDR,   8'h3F, 8'h00), 0, 8'h00},
         '{make_item(vcri_pkg::OP_WRITE,  vcri_pkg::ADDR_VADDR,   8'h10, 8'h00), 0, 8'h00},
         '{make_item(vcri_pkg::OP_WRITE,  vcri_pkg::ADDR_VDATA,   8'h2C, 8'h00), 0, 8'h00},
         '{make_item(vcri_pkg::OP_WRITE,  vcri_pkg::ADDR_MIRROR,  8'h00, 8'h00), 0, 8'h00},
         '{make_item(vcri_pkg::OP_WRITE,  vcri_pkg::ADDR_BANKSEL, 8'h87, 8'h00), 0, 8'h00},
         '{make_item(vcri_pkg::OP_WRITE,  vcri_pkg::ADDR_BANKDAT, 8'hFF, 8'h00), 0, 8'h00},
         '{make_item(vcri_pkg::OP_WRITE,  vcri_pkg::ADDR_PAD,     8'h01, 8'hFF), 0, 8'h00},
         '{make_item(vcri_pkg::OP_READ,   vcri_pkg::ADDR_PAD,     8'h00, 8'h00), 1, 8'h00},
         '{make_item(vcri_pkg::OP_WRITE,  vcri_pkg::ADDR_PAD,     8'h00, 8'h00), 0, 8'h00},
         '{make_item(vcri_pkg::OP_READ,   vcri_pkg::ADDR_PAD,     8'h00, 8'h00), 1, 8'h01},
         '{make_item(vcri_pkg::OP_WRITE,  16'h4014,               8'hFF, 8'hFF), 0, 8'h00}
      };
      foreach (rows[i]) send_item(rows[i].r, rows[i].fixed, rows[i].rd);

      for (int i = 0; i < ITEM_COUNT; i++) begin
         if (i == ITEM_COUNT - CALM_TAIL) calm = 1'b1;
         send_item(random_item(), 0, 8'h00);
      end
      req_valid <= 1'b0;
      stim_done = 1'b1;
   end

   // Result stalls come in bursts; none are raised during reset or the calm tail.
   always @(negedge clock) begin
      if (reset || calm) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else if ($urandom_range(0, 5) == 0) begin
         rsp_stall <= 1'b1;
         stall_left = $urandom_range(0, 7);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      vcri_pkg::rsp_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         responses_seen++;
         if (response_queue.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("result item arrived with none expected");
         end else begin
            e = response_queue.pop_front();
            if (rsp_data.read_data != 8'h00) reads_seen++;
            if (rsp_data !== e) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("result %0d: expected %h actual %h", responses_seen, e, rsp_data);
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("** video_chip_register_interface: FAILED **");
         $finish;
      end
   end

   initial begin
      wait (stim_done && response_queue.size() == 0);
      repeat (20) @(posedge clock);
      $display("Checked %0d result items, %0d of them with nonzero read data.",
               responses_seen, reads_seen);
      if (mismatches == 0 && response_queue.size() == 0)
         $display("** video_chip_register_interface: PASSED **");
      else
         $display("** video_chip_register_interface: FAILED **");
      $finish;
   end

endmodule

// File: filelist.f
hdl/vcri_pkg.sv
hdl/vcri_chr_map.sv
hdl/video_chip_register_interface.sv
hdl/vcri_checker.sv
tb/tb.sv
